### rtl/mfbr_pkg.sv
`timescale 1ns / 1ps
package mfbr_pkg;

    localparam int SCREEN_WIDTH_DEF  = 128;
    localparam int SCREEN_HEIGHT_DEF = 64;
    localparam int STORE_DEPTH       = 1024;
    localparam int ADDR_W            = 10;
    localparam int PAGE_STRIDE       = 128;
    localparam int COORD_W           = 11;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [ADDR_W-1:0]         addr_t;
    typedef logic [7:0]                byte_t;

    localparam logic [2:0] OP_POINT      = 3'd0;
    localparam logic [2:0] OP_READ_POINT = 3'd1;
    localparam logic [2:0] OP_LINE       = 3'd2;
    localparam logic [2:0] OP_CIRCLE     = 3'd3;
    localparam logic [2:0] OP_DISC       = 3'd4;
    localparam logic [2:0] OP_FILL       = 3'd5;
    localparam logic [2:0] OP_READ_BYTE  = 3'd6;

    localparam byte_t FILL_ONES = 8'hff;
    localparam byte_t BIT_ONE   = 8'h01;

endpackage

### rtl/mfbr_store.sv
`timescale 1ns / 1ps
module mfbr_store (
    input  logic            clk,
    input  logic            we,
    input  mfbr_pkg::addr_t waddr,
    input  mfbr_pkg::byte_t wdata,
    input  mfbr_pkg::addr_t raddr,
    output mfbr_pkg::byte_t rdata
);
    import mfbr_pkg::*;

    byte_t mem [STORE_DEPTH];
    byte_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/mono_framebuffer_rasterizer_unit.sv
`timescale 1ns / 1ps
// drawing engine for a page-organized one-bit framebuffer (8 rows per byte,
// one byte per column, 1024 bytes). a command transaction is taken when start
// is high and busy is low; busy stays high until the command is finished.
// read point and read byte return one result: read_valid is high for exactly
// one cycle with read_data, and the receiver cannot stall it. other commands
// return nothing. a point reads its byte, then writes it back (read point gives
// the bit instead), a line does so at each major axis pixel, a circle squares
// the radius and clips its bounding box, then checks each box pixel (one shared
// multiplier squares the radius and the offsets, a new column squares x again,
// each hit adds a read-modify-write), fill writes all 1024 bytes, one a cycle.
// reset starts a clearing pass with busy high. off-screen pixels are dropped.
module mono_framebuffer_rasterizer_unit #(
    parameter int SCREEN_WIDTH  = mfbr_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = mfbr_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [2:0]              opcode,
    input  logic signed [7:0]       ax,
    input  logic signed [7:0]       ay,
    input  logic signed [7:0]       bx,
    input  logic signed [7:0]       by,
    input  logic [7:0]              radius,
    input  logic                    color,
    input  logic [9:0]              byte_index,
    output logic                    read_valid,
    output logic [7:0]              read_data
);
    import mfbr_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_FILL    = 11'b000_0000_0010,
        S_PLOT_RD = 11'b000_0000_0100,
        S_PLOT_WR = 11'b000_0000_1000,
        S_RDOUT   = 11'b000_0001_0000,
        S_LSTEP   = 11'b000_0010_0000,
        S_CINIT   = 11'b000_0100_0000,
        S_CSQX    = 11'b000_1000_0000,
        S_CSQY    = 11'b001_0000_0000,
        S_CCMP    = 11'b010_0000_0000,
        S_CNEXT   = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // command registers
    logic [2:0] op_reg, op_next;
    logic       color_reg, color_next;
    byte_t      fill_reg, fill_next;
    addr_t      cnt_reg, cnt_next;          // sweep position for fill / clear
    coord_t     px_reg, px_next, py_reg, py_next;

    // line walk
    coord_t     maj_reg, maj_next, maj_end_reg, maj_end_next;
    coord_t     min_base_reg, min_base_next;
    logic       neg_reg, neg_next, steep_reg, steep_next;
    logic [8:0] step_reg, step_next, div_reg, div_next;
    logic [8:0] acc_reg, acc_next, q_reg, q_next;

    // circle scan
    coord_t      cx_reg, cx_next, cy_reg, cy_next;
    logic [7:0]  r_reg, r_next;
    coord_t      i_reg, i_next, j_reg, j_next;
    coord_t      x1_reg, x1_next, y0_reg, y0_next, y1_reg, y1_next;
    logic [17:0] r2_reg, r2_next, sqx_reg, sqx_next, sqy_reg, sqy_next;

    // result register
    logic  valid_reg, valid_next;
    byte_t data_reg, data_next;

    // store port
    logic  mem_we;
    addr_t mem_waddr, mem_raddr;
    byte_t mem_wdata, mem_rdata;

    mfbr_store u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // pixel address: page * 128 + column, dropped when past the store
    logic [COORD_W-1:0] pix_full;
    logic               pix_ok;
    byte_t              pix_mask;
    assign pix_full = {py_reg[6:3], px_reg[6:0]};
    assign pix_ok   = (px_reg >= 0) && (px_reg < coord_t'(SCREEN_WIDTH))
                   && (py_reg >= 0) && (py_reg < coord_t'(SCREEN_HEIGHT))
                   && (pix_full < COORD_W'(STORE_DEPTH));
    assign pix_mask = BIT_ONE << py_reg[2:0];

    // line setup from the command fields
    coord_t     ax_w, ay_w, bx_w, by_w, ldx, ldy, ladx, lady;
    logic       lsteep, lswap;
    assign ax_w   = coord_t'(ax);
    assign ay_w   = coord_t'(ay);
    assign bx_w   = coord_t'(bx);
    assign by_w   = coord_t'(by);
    assign ldx    = bx_w - ax_w;
    assign ldy    = by_w - ay_w;
    assign ladx   = (ldx < 0) ? -ldx : ldx;
    assign lady   = (ldy < 0) ? -ldy : ldy;
    assign lsteep = lady > ladx;
    assign lswap  = lsteep ? (ay_w > by_w) : (ax_w > bx_w);

    // line minor coordinate from the running quotient
    coord_t     lminor;
    logic [9:0] acc_sum;
    assign lminor  = neg_reg ? (min_base_reg - coord_t'(q_reg))
                             : (min_base_reg + coord_t'(q_reg));
    assign acc_sum = {1'b0, acc_reg} + {1'b0, step_reg};

    // circle bounding box, clipped to the screen
    coord_t cx_lo, cx_hi, cy_lo, cy_hi, bx0, bx1, by0, by1;
    assign cx_lo = cx_reg - coord_t'(r_reg);
    assign cx_hi = cx_reg + coord_t'(r_reg);
    assign cy_lo = cy_reg - coord_t'(r_reg);
    assign cy_hi = cy_reg + coord_t'(r_reg);
    assign bx0   = (cx_lo < 0) ? '0 : cx_lo;
    assign by0   = (cy_lo < 0) ? '0 : cy_lo;
    assign bx1   = (cx_hi > coord_t'(SCREEN_WIDTH - 1))  ? coord_t'(SCREEN_WIDTH - 1)  : cx_hi;
    assign by1   = (cy_hi > coord_t'(SCREEN_HEIGHT - 1)) ? coord_t'(SCREEN_HEIGHT - 1) : cy_hi;

    // shared squaring multiplier
    coord_t      mdiff;
    coord_t      mabs;
    logic [8:0]  mul_a;
    logic [17:0] mul_p;
    logic [18:0] d2;
    logic        c_hit;
    always_comb
    begin
        mdiff = (state_reg == S_CSQX) ? (i_reg - cx_reg) : (j_reg - cy_reg);
        mabs  = (mdiff < 0) ? -mdiff : mdiff;
        mul_a = (state_reg == S_CINIT) ? {1'b0, r_reg} : mabs[8:0];
    end
    assign mul_p = mul_a * mul_a;
    assign d2    = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign c_hit = (op_reg == OP_DISC) ? (d2 < {1'b0, r2_reg}) : (d2 == {1'b0, r2_reg});

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        color_next    = color_reg;
        fill_next     = fill_reg;
        cnt_next      = cnt_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        maj_next      = maj_reg;
        maj_end_next  = maj_end_reg;
        min_base_next = min_base_reg;
        neg_next      = neg_reg;
        steep_next    = steep_reg;
        step_next     = step_reg;
        div_next      = div_reg;
        acc_next      = acc_reg;
        q_next        = q_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        r_next        = r_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        x1_next       = x1_reg;
        y0_next       = y0_reg;
        y1_next       = y1_reg;
        r2_next       = r2_reg;
        sqx_next      = sqx_reg;
        sqy_next      = sqy_reg;
        valid_next    = 1'b0;
        data_next     = data_reg;
        mem_we        = 1'b0;
        mem_waddr     = pix_full[ADDR_W-1:0];
        mem_wdata     = color_reg ? (mem_rdata | pix_mask) : (mem_rdata & ~pix_mask);
        mem_raddr     = pix_full[ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                mem_raddr = byte_index;
                if (start)
                begin
                    op_next    = opcode;
                    color_next = color;
                    px_next    = ax_w;
                    py_next    = ay_w;
                    cx_next    = ax_w;
                    cy_next    = ay_w;
                    r_next     = radius;
                    unique case (opcode)
                        OP_POINT, OP_READ_POINT: state_next = S_PLOT_RD;
                        OP_LINE:
                        begin
                            steep_next    = lsteep;
                            maj_next      = lsteep ? (lswap ? by_w : ay_w) : (lswap ? bx_w : ax_w);
                            maj_end_next  = lsteep ? (lswap ? ay_w : by_w) : (lswap ? ax_w : bx_w);
                            min_base_next = lsteep ? (lswap ? bx_w : ax_w) : (lswap ? by_w : ay_w);
                            neg_next      = lsteep ? (lswap ? (ldx > 0) : (ldx < 0))
                                                   : (lswap ? (ldy > 0) : (ldy < 0));
                            step_next     = lsteep ? ladx[8:0] : lady[8:0];
                            div_next      = lsteep ? lady[8:0] : ladx[8:0];
                            acc_next      = '0;
                            q_next        = '0;
                            // degenerate line draws nothing
                            state_next    = ((ldx == 0) && (ldy == 0)) ? S_IDLE : S_LSTEP;
                        end
                        OP_CIRCLE, OP_DISC: state_next = S_CINIT;
                        OP_FILL:
                        begin
                            fill_next  = color ? FILL_ONES : '0;
                            cnt_next   = '0;
                            state_next = S_FILL;
                        end
                        OP_READ_BYTE: state_next = S_RDOUT;
                        default:      state_next = S_IDLE;
                    endcase
                end
            end
            S_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = fill_reg;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == addr_t'(STORE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_PLOT_RD: state_next = S_PLOT_WR;
            S_PLOT_WR:
            begin
                if (op_reg == OP_READ_POINT)
                begin
                    valid_next = 1'b1;
                    data_next  = {7'd0, pix_ok & mem_rdata[py_reg[2:0]]};
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_we = pix_ok;
                    if (op_reg == OP_LINE)
                    begin
                        if (maj_reg == maj_end_reg)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            maj_next = maj_reg + 1'b1;
                            // running trunc(step * k / div), one compare-subtract a step
                            if (acc_sum >= {1'b0, div_reg})
                            begin
                                acc_next = 9'(acc_sum - {1'b0, div_reg});
                                q_next   = q_reg + 1'b1;
                            end
                            else
                            begin
                                acc_next = acc_sum[8:0];
                            end
                            state_next = S_LSTEP;
                        end
                    end
                    else if ((op_reg == OP_CIRCLE) || (op_reg == OP_DISC))
                    begin
                        state_next = S_CNEXT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_RDOUT:
            begin
                valid_next = 1'b1;
                data_next  = mem_rdata;
                state_next = S_IDLE;
            end
            S_LSTEP:
            begin
                px_next    = steep_reg ? lminor : maj_reg;
                py_next    = steep_reg ? maj_reg : lminor;
                state_next = S_PLOT_RD;
            end
            S_CINIT:
            begin
                r2_next = mul_p;
                i_next  = bx0;
                j_next  = by0;
                x1_next = bx1;
                y0_next = by0;
                y1_next = by1;
                state_next = ((bx0 > bx1) || (by0 > by1)) ? S_IDLE : S_CSQX;
            end
            S_CSQX:
            begin
                sqx_next   = mul_p;
                state_next = S_CSQY;
            end
            S_CSQY:
            begin
                sqy_next   = mul_p;
                state_next = S_CCMP;
            end
            S_CCMP:
            begin
                px_next    = i_reg;
                py_next    = j_reg;
                state_next = c_hit ? S_PLOT_RD : S_CNEXT;
            end
            S_CNEXT:
            begin
                if (j_reg == y1_reg)
                begin
                    if (i_reg == x1_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        j_next     = y0_reg;
                        state_next = S_CSQX;
                    end
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_CSQY;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control state; reset starts the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_FILL;
            cnt_reg   <= '0;
            fill_reg  <= '0;
            valid_reg <= 1'b0;
            op_reg    <= OP_POINT;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            fill_reg  <= fill_next;
            valid_reg <= valid_next;
            op_reg    <= op_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        color_reg    <= color_next;
        px_reg       <= px_next;
        py_reg       <= py_next;
        maj_reg      <= maj_next;
        maj_end_reg  <= maj_end_next;
        min_base_reg <= min_base_next;
        neg_reg      <= neg_next;
        steep_reg    <= steep_next;
        step_reg     <= step_next;
        div_reg      <= div_next;
        acc_reg      <= acc_next;
        q_reg        <= q_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        r_reg        <= r_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        x1_reg       <= x1_next;
        y0_reg       <= y0_next;
        y1_reg       <= y1_next;
        r2_reg       <= r2_next;
        sqx_reg      <= sqx_next;
        sqy_reg      <= sqy_next;
        data_reg     <= data_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign read_valid = valid_reg;
    assign read_data  = data_reg;

endmodule

### verif/mono_framebuffer_rasterizer_unit_tb.sv
`timescale 1ns / 1ps
module mono_framebuffer_rasterizer_unit_tb;
    import mfbr_pkg::*;

    // opcode 7 is not decoded by the block
    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int SCR_W = SCREEN_WIDTH_DEF;
    localparam int SCR_H = SCREEN_HEIGHT_DEF;
    // generous bound on the whole run, in clock cycles
    localparam int CYCLE_LIMIT = 4000000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [2:0]        opcode = OP_POINT;
    logic signed [7:0] ax = '0;
    logic signed [7:0] ay = '0;
    logic signed [7:0] bx = '0;
    logic signed [7:0] by = '0;
    logic [7:0]        radius = '0;
    logic              color = 1'b0;
    logic [9:0]        byte_index = '0;
    logic              read_valid;
    logic [7:0]        read_data;

    // shadow copy of the framebuffer, kept in step with accepted commands
    byte_t frame_shadow [STORE_DEPTH] = '{default: 8'h00};
    // read results still owed by the block, oldest first
    byte_t pending_reads [$];

    int fail_count = 0;
    int cmd_count = 0;
    int read_count = 0;
    int cycle_count = 0;
    int sender_idle_pct = 0;

    mono_framebuffer_rasterizer_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .ax         (ax),
        .ay         (ay),
        .bx         (bx),
        .by         (by),
        .radius     (radius),
        .color      (color),
        .byte_index (byte_index),
        .read_valid (read_valid),
        .read_data  (read_data)
    );

    always #2 clk = ~clk;

    // byte address of a pixel, or -1 when it falls off the screen
    function automatic int pixel_addr(int x, int y);
        int a;
        if (x < 0 || x >= SCR_W || y < 0 || y >= SCR_H)
            return -1;
        a = (y >> 3) * PAGE_STRIDE + x;
        if (a >= STORE_DEPTH)
            return -1;
        return a;
    endfunction

    task automatic plot(int x, int y, bit on);
        int a;
        a = pixel_addr(x, y);
        if (a >= 0)
        begin
            if (on)
                frame_shadow[a] = frame_shadow[a] | (BIT_ONE << (y & 7));
            else
                frame_shadow[a] = frame_shadow[a] & ~(BIT_ONE << (y & 7));
        end
    endtask

    task automatic trace_line(int x1, int y1, int x2, int y2, bit on);
        int dx, dy, t, i, lo, hi;
        dx = x2 - x1;
        dy = y2 - y1;
        if (dx == 0 && dy == 0)
            return;
        if (dy == 0)
        begin
            lo = (x1 < x2) ? x1 : x2;
            hi = (x1 < x2) ? x2 : x1;
            for (i = lo; i <= hi; i++)
                plot(i, y1, on);
            return;
        end
        if (dx == 0)
        begin
            lo = (y1 < y2) ? y1 : y2;
            hi = (y1 < y2) ? y2 : y1;
            for (i = lo; i <= hi; i++)
                plot(x1, i, on);
            return;
        end
        // shallow lines step along x, steep ones along y; whole endpoints swap
        if ((dy < 0 ? -dy : dy) <= (dx < 0 ? -dx : dx))
        begin
            if (x1 > x2)
            begin
                t = x1; x1 = x2; x2 = t;
                t = y1; y1 = y2; y2 = t;
                dx = -dx; dy = -dy;
            end
            for (i = x1; i <= x2; i++)
                plot(i, y1 + (dy * (i - x1)) / dx, on);
        end
        else
        begin
            if (y1 > y2)
            begin
                t = x1; x1 = x2; x2 = t;
                t = y1; y1 = y2; y2 = t;
                dx = -dx; dy = -dy;
            end
            for (i = y1; i <= y2; i++)
                plot(x1 + (dx * (i - y1)) / dy, i, on);
        end
    endtask

    // bounding box scan clipped to the screen; outline on d2 == r2, disc on d2 < r2
    task automatic trace_circle(int cx, int cy, int r, bit filled, bit on);
        int r2, x0, x1, y0, y1, i, j, d2;
        r2 = r * r;
        x0 = (cx - r < 0) ? 0 : cx - r;
        y0 = (cy - r < 0) ? 0 : cy - r;
        x1 = (cx + r > SCR_W - 1) ? SCR_W - 1 : cx + r;
        y1 = (cy + r > SCR_H - 1) ? SCR_H - 1 : cy + r;
        for (i = x0; i <= x1; i++)
            for (j = y0; j <= y1; j++)
            begin
                d2 = (i - cx) * (i - cx) + (j - cy) * (j - cy);
                if (filled ? (d2 < r2) : (d2 == r2))
                    plot(i, j, on);
            end
    endtask

    // advance the shadow framebuffer by one accepted command
    task automatic apply_command(logic [2:0] op, int pax, int pay, int pbx, int pby,
                                 int r, bit on, int idx);
        int a;
        case (op)
            OP_POINT:      plot(pax, pay, on);
            OP_READ_POINT:
            begin
                a = pixel_addr(pax, pay);
                pending_reads.push_back((a < 0) ? 8'h00 : ((frame_shadow[a] >> (pay & 7)) & BIT_ONE));
            end
            OP_LINE:       trace_line(pax, pay, pbx, pby, on);
            OP_CIRCLE:     trace_circle(pax, pay, r, 1'b0, on);
            OP_DISC:       trace_circle(pax, pay, r, 1'b1, on);
            OP_FILL:
                for (a = 0; a < STORE_DEPTH; a++)
                    frame_shadow[a] = on ? FILL_ONES : 8'h00;
            OP_READ_BYTE:  pending_reads.push_back(frame_shadow[idx]);
            default: ;
        endcase
    endtask

    // drive one command transaction at the falling edge, hold until taken
    task automatic send_cmd(logic [2:0] op, logic signed [7:0] pax, logic signed [7:0] pay,
                            logic signed [7:0] pbx, logic signed [7:0] pby,
                            logic [7:0] r, bit on, logic [9:0] idx);
        int gap;
        if ($urandom_range(99) < sender_idle_pct)
        begin
            gap = $urandom_range(6, 1);
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        opcode = op;
        ax = pax;
        ay = pay;
        bx = pbx;
        by = pby;
        radius = r;
        color = on;
        byte_index = idx;
        start = 1'b1;
        do
            @(posedge clk);
        while (busy);
        cmd_count++;
        apply_command(op, int'(pax), int'(pay), int'(pbx), int'(pby), int'(r), on, int'(idx));
    endtask

    task automatic read_byte(logic [9:0] idx);
        send_cmd(OP_READ_BYTE, 0, 0, 0, 0, 0, 1'b0, idx);
    endtask

    // read back the five bytes of the page that holds row y, columns x-2 to x+2
    task automatic probe_around(int x, int y);
        int c;
        for (c = -2; c <= 2; c++)
            read_byte(10'(((y & 63) >> 3) * PAGE_STRIDE + ((x + c) & 127)));
    endtask

    // result checker: read_valid lasts one cycle and cannot be stalled
    always @(posedge clk)
    begin
        if (rst_n && read_valid)
        begin
            read_count++;
            if (pending_reads.size() == 0)
            begin
                $error("read_data: no result expected, actual %0h", read_data);
                fail_count++;
            end
            else
            begin
                if (read_data !== pending_reads[0])
                begin
                    $error("read_data: expected %0h, actual %0h", pending_reads[0], read_data);
                    fail_count++;
                end
                void'(pending_reads.pop_front());
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("mono_framebuffer_rasterizer_unit: mismatch");
            $finish;
        end
    end

    // single pixels at two screen corners and off the screen, and reads on and off it
    task automatic test_points();
        send_cmd(OP_POINT, 0, 0, 0, 0, 0, 1'b1, 0);
        send_cmd(OP_POINT, 127, 63, 0, 0, 0, 1'b1, 0);
        send_cmd(OP_POINT, -128, 127, 0, 0, 0, 1'b1, 0);
        send_cmd(OP_POINT, 127, -1, 0, 0, 0, 1'b1, 0);
        send_cmd(OP_READ_POINT, 0, 0, 0, 0, 0, 1'b0, 0);
        send_cmd(OP_READ_POINT, 127, 63, 0, 0, 0, 1'b0, 0);
        send_cmd(OP_READ_POINT, 127, 64, 0, 0, 0, 1'b0, 0);
        send_cmd(OP_READ_POINT, -1, 0, 0, 0, 0, 1'b0, 0);
        send_cmd(OP_POINT, 0, 0, 0, 0, 0, 1'b0, 0);
        read_byte(0);
        read_byte(10'd1023);
        // unused opcode must leave the buffer alone
        send_cmd(OP_UNUSED, 5, 5, 9, 9, 8'hff, 1'b1, 10'h3ff);
        read_byte(10'd5);
    endtask

    // degenerate, straight, shallow, steep and reversed lines
    task automatic test_lines();
        send_cmd(OP_LINE, 10, 10, 10, 10, 0, 1'b1, 0);
        send_cmd(OP_LINE, 120, 3, -128, 3, 0, 1'b1, 0);
        send_cmd(OP_LINE, 7, 127, 7, -128, 0, 1'b1, 0);
        send_cmd(OP_LINE, 100, 40, 20, 30, 0, 1'b1, 0);
        send_cmd(OP_LINE, 50, 60, 40, 2, 0, 1'b1, 0);
        send_cmd(OP_LINE, -128, -128, 127, 127, 0, 1'b1, 0);
        probe_around(10, 10);
        probe_around(60, 35);
        probe_around(45, 30);
    endtask

    // radius zero for both kinds, a small outline, a clipped large disc, and a full-radius outline
    task automatic test_circles();
        send_cmd(OP_FILL, 0, 0, 0, 0, 0, 1'b0, 0);
        send_cmd(OP_CIRCLE, 30, 30, 0, 0, 0, 1'b1, 0);
        send_cmd(OP_DISC, 40, 30, 0, 0, 0, 1'b1, 0);
        send_cmd(OP_CIRCLE, 64, 32, 0, 0, 8'd5, 1'b1, 0);
        probe_around(30, 30);
        probe_around(40, 30);
        probe_around(64, 27);
        send_cmd(OP_DISC, 127, 0, 0, 0, 8'd30, 1'b1, 0);
        probe_around(110, 8);
        send_cmd(OP_CIRCLE, -128, -128, 0, 0, 8'd255, 1'b1, 0);
        probe_around(100, 40);
    endtask

    task automatic test_fill();
        send_cmd(OP_FILL, 0, 0, 0, 0, 0, 1'b1, 0);
        read_byte(10'd513);
        send_cmd(OP_DISC, 64, 32, 0, 0, 8'd4, 1'b0, 0);
        probe_around(64, 32);
        send_cmd(OP_FILL, 0, 0, 0, 0, 0, 1'b0, 0);
        read_byte(10'd1023);
    endtask

    // mostly on or near the screen, sometimes anywhere in the signed range
    function automatic logic signed [7:0] pick_x();
        return ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(135) - 4);
    endfunction

    function automatic logic signed [7:0] pick_y();
        return ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(71) - 4);
    endfunction

    // random command mix with read-backs around what was drawn
    task automatic test_random(int count, int idle_pct);
        int n, sel;
        logic signed [7:0] px, py;
        logic [7:0] r;
        sender_idle_pct = idle_pct;
        for (n = 0; n < count; n++)
        begin
            sel = $urandom_range(99);
            px = pick_x();
            py = pick_y();
            // small radii keep the run short; a few large and full-range ones
            r = 8'($urandom_range(6));
            if ($urandom_range(99) < 3)
                r = 8'($urandom_range(30));
            if ($urandom_range(399) == 0)
                r = 8'($urandom);
            if (sel < 15)
                send_cmd(OP_POINT, px, py, 8'($urandom), 8'($urandom), 8'($urandom),
                         1'($urandom), 10'($urandom));
            else if (sel < 27)
                send_cmd(OP_READ_POINT, px, py, 8'($urandom), 8'($urandom), 8'($urandom),
                         1'($urandom), 10'($urandom));
            else if (sel < 45)
                send_cmd(OP_LINE, px, py, pick_x(), pick_y(), 8'($urandom),
                         1'($urandom), 10'($urandom));
            else if (sel < 55)
                send_cmd(OP_CIRCLE, px, py, 8'($urandom), 8'($urandom), r,
                         1'($urandom), 10'($urandom));
            else if (sel < 65)
                send_cmd(OP_DISC, px, py, 8'($urandom), 8'($urandom), r,
                         1'($urandom), 10'($urandom));
            else if (sel < 68)
                send_cmd(OP_FILL, px, py, 8'($urandom), 8'($urandom), 8'($urandom),
                         1'($urandom), 10'($urandom));
            else if (sel < 70)
                send_cmd(OP_UNUSED, px, py, 8'($urandom), 8'($urandom), 8'($urandom),
                         1'($urandom), 10'($urandom));
            else if (sel < 85)
                read_byte(10'($urandom));
            else
                // read near the last point to see fresh drawing
                read_byte(10'(((int'(py) & 63) >> 3) * PAGE_STRIDE + (int'(px) & 127)));
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        sender_idle_pct = 0;
        test_points();
        test_lines();
        test_circles();
        test_fill();
        test_random(208, 26);
        test_random(208, 56);
        test_random(208, 0);

        @(negedge clk);
        start = 1'b0;
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        $display("ran %0d command transactions, checked %0d read results", cmd_count,
                 read_count);
        $display("covered points, lines, circle outlines, discs, fills and byte reads");
        if (fail_count == 0)
            $display("mono_framebuffer_rasterizer_unit: match");
        else
            $display("mono_framebuffer_rasterizer_unit: mismatch");
        $finish;
    end

endmodule
